[design/aoxrt_pkg.sv]
package aoxrt_pkg;

	localparam int unsigned INDEX_BITS = 10;
	localparam int unsigned LEAF_BITS  = 30;
	localparam int unsigned LEVEL_BITS = 4;

	localparam logic [LEVEL_BITS-1:0] LEVELS_RESET = 4'd10;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_WALK  = 3'b100
	} state_t;

endpackage

[design/alternating_or_xor_reduction_tree_core.sv]
// Reduction tree over 2^levels_in_use leaves (levels_in_use capped at MAX_LEVELS), OR at
// odd heights and XOR at even heights. A request is accepted when start is high and busy
// is low. The accepting cycle writes the leaf, then the walk state goes up the levels to
// the top through a single combiner and the node memory, which is read at one sibling
// address and written at one parent address each cycle. An update request (opcode 1)
// raises done for exactly one cycle, in the cycle after the last level, with root_value
// beside it; busy is already low then, so the next request may be accepted in that cycle.
// The receiver cannot stall: a result not taken in its cycle is gone. After reset all
// 2^(MAX_LEVELS+1) node slots (2048 at the defaults) are cleared in a pass with busy held
// high. Write levels_in_use through levels_we/levels_wdata only while no request is in
// flight.
module alternating_or_xor_reduction_tree_core #(
	parameter int unsigned MAX_LEVELS = 10,
	parameter int unsigned VALUE_BITS = 30
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              levels_we,
	input  logic [aoxrt_pkg::LEVEL_BITS-1:0]  levels_wdata,
	input  logic                              start,
	output logic                              busy,
	input  logic                              opcode,
	input  logic [aoxrt_pkg::INDEX_BITS-1:0]  leaf_index,
	input  logic [aoxrt_pkg::LEAF_BITS-1:0]   leaf_value,
	output logic                              done,
	output logic [aoxrt_pkg::LEAF_BITS-1:0]   root_value
);
	import aoxrt_pkg::*;

	localparam int unsigned ADDR_BITS  = MAX_LEVELS + 1;
	localparam int unsigned NODE_SLOTS = 2 ** ADDR_BITS;
	localparam int unsigned HGT_BITS   = $clog2(MAX_LEVELS + 1);

	state_t                   state_q;
	logic [LEVEL_BITS-1:0]    levels_q;
	logic [ADDR_BITS-1:0]     clr_q;
	logic [HGT_BITS-1:0]      h_q;
	logic [ADDR_BITS-1:0]     base_q;
	logic [MAX_LEVELS-1:0]    pos_q;
	logic [VALUE_BITS-1:0]    cur_q;
	logic [VALUE_BITS-1:0]    rd_q;
	logic [VALUE_BITS-1:0]    root_q;
	logic                     op_q;
	logic                     done_q;

	logic [VALUE_BITS-1:0]    node_mem_q [NODE_SLOTS];

	logic                     accept;
	logic [HGT_BITS-1:0]      depth;
	logic [MAX_LEVELS-1:0]    depth_mask;
	logic [MAX_LEVELS+INDEX_BITS-1:0] idx_ext;
	logic [VALUE_BITS+LEAF_BITS-1:0]  val_ext;
	logic [VALUE_BITS+LEAF_BITS-1:0]  root_ext;
	logic [MAX_LEVELS-1:0]    pos0;
	logic [VALUE_BITS-1:0]    val;
	logic [VALUE_BITS-1:0]    comb;
	logic [ADDR_BITS-1:0]     base_top;
	logic                     wr_en;
	logic [ADDR_BITS-1:0]     wr_addr;
	logic [VALUE_BITS-1:0]    wr_data;
	logic [ADDR_BITS-1:0]     rd_addr;
	logic                     last_level;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign depth = (int'(levels_q) > int'(MAX_LEVELS)) ? HGT_BITS'(MAX_LEVELS)
	                                                   : HGT_BITS'(levels_q);
	assign depth_mask = ~({MAX_LEVELS{1'b1}} << depth);
	assign idx_ext    = {{MAX_LEVELS{1'b0}}, leaf_index};
	assign pos0       = idx_ext[MAX_LEVELS-1:0] & depth_mask;
	assign val_ext    = {{VALUE_BITS{1'b0}}, leaf_value};
	assign val        = val_ext[VALUE_BITS-1:0];
	assign base_top   = {1'b1, {MAX_LEVELS{1'b0}}};

	assign comb       = h_q[0] ? (cur_q | rd_q) : (cur_q ^ rd_q);
	assign last_level = (h_q == HGT_BITS'(MAX_LEVELS));

	assign root_ext   = {{LEAF_BITS{1'b0}}, root_q};
	assign root_value = root_ext[LEAF_BITS-1:0];
	assign done       = done_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = base_q | {1'b0, pos_q};
		wr_data = comb;
		rd_addr = base_q | {1'b0, pos_q ^ MAX_LEVELS'(1)};
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_IDLE: begin
				wr_en   = accept;
				wr_addr = base_top | {1'b0, pos0};
				wr_data = val;
				rd_addr = base_top | {1'b0, pos0 ^ MAX_LEVELS'(1)};
			end
			ST_WALK: begin
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			node_mem_q[wr_addr] <= wr_data;
		end
		rd_q <= node_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			levels_q <= LEVELS_RESET;
			clr_q    <= '0;
			h_q      <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (levels_we) begin
				levels_q <= levels_wdata;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_BITS'(1);
					if (clr_q == {ADDR_BITS{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						h_q     <= HGT_BITS'(1);
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					h_q <= h_q + HGT_BITS'(1);
					if (last_level) begin
						done_q  <= op_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			cur_q  <= val;
			base_q <= base_top >> 1;
			pos_q  <= pos0 >> 1;
			if (depth == '0) begin
				root_q <= val;
			end
		end else if (state_q == ST_WALK) begin
			cur_q  <= comb;
			base_q <= base_q >> 1;
			pos_q  <= pos_q >> 1;
			if (h_q == depth) begin
				root_q <= comb;
			end
		end
	end

`ifndef SYNTHESIS
	a_accept_walk: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_WALK) && (h_q == HGT_BITS'(1)))
		else $error("walk did not start after request");

	a_height_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (h_q >= HGT_BITS'(1)) && (h_q <= HGT_BITS'(MAX_LEVELS)))
		else $error("height out of range during walk");

	a_done_after_top: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_WALK) && $past(last_level) && $past(op_q))
		else $error("result strobe without finished update");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe while busy");

	a_clear_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CLEAR) && (clr_q == {ADDR_BITS{1'b1}})) |=> (state_q == ST_IDLE))
		else $error("clearing pass did not end");
`endif

endmodule

[dv/aoxrt_test_pkg.sv]
`timescale 1ns / 100ps

package aoxrt_test_pkg;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

endpackage

[dv/aoxrt_root_checker.sv]
`timescale 1ns / 100ps

module aoxrt_root_checker #(
	parameter int unsigned MAX_LEVELS = 10,
	parameter int unsigned VALUE_BITS = 30
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              levels_we,
	input  logic [aoxrt_pkg::LEVEL_BITS-1:0]  levels_wdata,
	input  logic                              start,
	input  logic                              busy,
	input  logic                              opcode,
	input  logic [aoxrt_pkg::INDEX_BITS-1:0]  leaf_index,
	input  logic [aoxrt_pkg::LEAF_BITS-1:0]   leaf_value,
	input  logic                              done,
	input  logic [aoxrt_pkg::LEAF_BITS-1:0]   root_value,
	output int unsigned                       fail_count,
	output int unsigned                       pending
);

	import aoxrt_pkg::*;
	import aoxrt_test_pkg::*;

	localparam int unsigned SLOTS = 2 << MAX_LEVELS;

	logic [VALUE_BITS-1:0]  tree_node [0:SLOTS-1];
	logic [LEVEL_BITS-1:0]  depth_reg;
	logic [LEAF_BITS-1:0]   expected_roots [$];

	// write one leaf, rebuild its path to the top, return the root at the current depth
	function automatic logic [VALUE_BITS-1:0] write_leaf(
		input logic [INDEX_BITS-1:0] idx,
		input logic [VALUE_BITS-1:0] val
	);
		int unsigned depth;
		int unsigned pos;
		int unsigned h;
		logic [VALUE_BITS-1:0] lhs;
		logic [VALUE_BITS-1:0] rhs;
		depth = (depth_reg > MAX_LEVELS) ? MAX_LEVELS : depth_reg;
		pos = idx & ((1 << depth) - 1);
		tree_node[(1 << MAX_LEVELS) + pos] = val;
		for (h = 1; h <= MAX_LEVELS; h++) begin
			pos = pos >> 1;
			lhs = tree_node[(1 << (MAX_LEVELS - h + 1)) + 2 * pos];
			rhs = tree_node[(1 << (MAX_LEVELS - h + 1)) + 2 * pos + 1];
			tree_node[(1 << (MAX_LEVELS - h)) + pos] = h[0] ? (lhs | rhs) : (lhs ^ rhs);
		end
		return tree_node[1 << (MAX_LEVELS - depth)];
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin : track
		logic [LEAF_BITS-1:0] want;
		if (!arst_n) begin
			for (int k = 0; k < SLOTS; k++)
				tree_node[k] = '0;
			depth_reg = LEVELS_RESET;
			expected_roots.delete();
		end else begin
			if (done) begin
				if (expected_roots.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected root_value %h with no update pending", root_value);
					fail_count++;
				end else begin
					want = expected_roots.pop_front();
					if (root_value !== want) begin
						if (fail_count < 10)
							$display("root_value mismatch: expected %h, got %h", want, root_value);
						fail_count++;
					end
				end
			end
			if (levels_we)
				depth_reg = levels_wdata;
			if (start && !busy) begin
				want = write_leaf(leaf_index, leaf_value);
				if (opcode == OP_UPDATE)
					expected_roots.push_back(want);
			end
		end
		pending = expected_roots.size();
	end

endmodule

[dv/alternating_or_xor_reduction_tree_core_test.sv]
`timescale 1ns / 100ps

module alternating_or_xor_reduction_tree_core_test;

	import aoxrt_pkg::*;
	import aoxrt_test_pkg::*;

	localparam int unsigned MAX_LEVELS = 10;
	localparam int unsigned VALUE_BITS = 30;
	localparam logic [LEAF_BITS-1:0] ALL_ONES = '1;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   levels_we;
	logic [LEVEL_BITS-1:0]  levels_wdata;
	logic                   start;
	logic                   busy;
	logic                   opcode;
	logic [INDEX_BITS-1:0]  leaf_index;
	logic [LEAF_BITS-1:0]   leaf_value;
	logic                   done;
	logic [LEAF_BITS-1:0]   root_value;

	int unsigned            fail_count;
	int unsigned            pending;
	logic                   req_taken;
	logic                   idle_seen;
	int unsigned            idle_max;

	alternating_or_xor_reduction_tree_core #(
		.MAX_LEVELS(MAX_LEVELS),
		.VALUE_BITS(VALUE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.levels_we(levels_we),
		.levels_wdata(levels_wdata),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.leaf_index(leaf_index),
		.leaf_value(leaf_value),
		.done(done),
		.root_value(root_value)
	);

	aoxrt_root_checker #(
		.MAX_LEVELS(MAX_LEVELS),
		.VALUE_BITS(VALUE_BITS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.levels_we(levels_we),
		.levels_wdata(levels_wdata),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.leaf_index(leaf_index),
		.leaf_value(leaf_value),
		.done(done),
		.root_value(root_value),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		req_taken <= arst_n && start && !busy;
		idle_seen <= arst_n && !busy;
	end

	task automatic send_request(
		input logic                  op,
		input logic [INDEX_BITS-1:0] idx,
		input logic [LEAF_BITS-1:0]  val
	);
		int unsigned gap;
		start <= 1'b1;
		opcode <= op;
		leaf_index <= idx;
		leaf_value <= val;
		do @(negedge clk); while (!req_taken);
		gap = $urandom_range(idle_max, 0);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_drained;
		start <= 1'b0;
		do @(negedge clk); while (pending != 0 || !idle_seen);
		// loads leave nothing to wait on; let the walk finish
		repeat (MAX_LEVELS + 4) @(negedge clk);
	endtask

	task automatic set_levels(input logic [LEVEL_BITS-1:0] lv);
		wait_drained();
		levels_we <= 1'b1;
		levels_wdata <= lv;
		@(negedge clk);
		levels_we <= 1'b0;
	endtask

	function automatic logic [LEAF_BITS-1:0] draw_value();
		case ($urandom_range(5, 0))
			0: return ALL_ONES;
			1: return '0;
			2: return LEAF_BITS'(1) << $urandom_range(LEAF_BITS - 1, 0);
			default: return LEAF_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [INDEX_BITS-1:0] draw_index();
		case ($urandom_range(3, 0))
			0: return INDEX_BITS'($urandom_range(7, 0));
			1: return INDEX_BITS'($urandom_range(1023, 1016));
			default: return INDEX_BITS'($urandom);
		endcase
	endfunction

	initial begin
		#(400_000 * 12);
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		logic [LEVEL_BITS-1:0] phase_levels [10];
		logic op;
		phase_levels = '{4'd10, 4'd1, 4'd4, 4'd0, 4'd11, 4'd15, 4'd7, 4'd2, 4'd10, 4'd5};
		arst_n = 1'b0;
		levels_we = 1'b0;
		levels_wdata = '0;
		start = 1'b0;
		opcode = OP_LOAD;
		leaf_index = '0;
		leaf_value = '0;
		idle_max = 7;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		set_levels(4'd10);
		send_request(OP_UPDATE, 10'd0, ALL_ONES);
		send_request(OP_UPDATE, 10'd1023, ALL_ONES);
		send_request(OP_LOAD, 10'd1, 30'h1555_5555);
		send_request(OP_UPDATE, 10'd512, '0);
		send_request(OP_LOAD, 10'd0, '0);
		send_request(OP_UPDATE, 10'd1023, '0);
		set_levels(4'd0);
		send_request(OP_UPDATE, 10'd1023, 30'h2AAA_AAAA);
		send_request(OP_LOAD, 10'd5, ALL_ONES);
		send_request(OP_UPDATE, 10'd0, 30'd1);
		set_levels(4'd15);
		send_request(OP_UPDATE, 10'd700, 30'd123);
		send_request(OP_UPDATE, 10'd3, ALL_ONES);
		set_levels(4'd3);
		send_request(OP_UPDATE, 10'd1023, ALL_ONES);
		send_request(OP_LOAD, 10'd8, 30'd5);
		send_request(OP_UPDATE, 10'd6, 30'd3);
		set_levels(4'd1);
		send_request(OP_UPDATE, 10'd1, ALL_ONES);
		send_request(OP_UPDATE, 10'd2, '0);

		for (int phase = 0; phase < 10; phase++) begin
			set_levels(phase_levels[phase]);
			idle_max = (phase % 3 == 0) ? 0 : 7;
			for (int n = 0; n < 130; n++) begin
				if (n == 60 && phase % 4 == 1)
					wait_drained();
				op = ($urandom_range(1, 0) != 0) ? OP_UPDATE : OP_LOAD;
				send_request(op, draw_index(), draw_value());
			end
		end

		wait_drained();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[alternating_or_xor_reduction_tree_core.f]
design/aoxrt_pkg.sv
design/alternating_or_xor_reduction_tree_core.sv
dv/aoxrt_test_pkg.sv
dv/aoxrt_root_checker.sv
dv/alternating_or_xor_reduction_tree_core_test.sv
